// ===== hw/rtl/proper_divisor_sum_classifier_defines.svh =====
// ----------------------------------------------------------------------------
// Proper divisor sum classifier: assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PROPER_DIVISOR_SUM_CLASSIFIER_DEFINES_SVH
`define PROPER_DIVISOR_SUM_CLASSIFIER_DEFINES_SVH

// Same-cycle implication
`define PDSC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define PDSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/pdsc_pkg.sv =====
// ----------------------------------------------------------------------------
// pdsc_pkg
// Types and constants shared by the controller, datapath and top level.
// ----------------------------------------------------------------------------
package pdsc_pkg;

  // Result field widths
  localparam int unsigned SUM_W = 36;
  localparam int unsigned OUT_W = 40;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_ACC_D,
    ST_ACC_Q,
    ST_FINISH
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture number, reset divisor and sum
    logic div_init;  // start a division n / d
    logic div_step;  // one restoring division step
    logic add_d;     // add d if it divides n
    logic add_q;     // add n/d if it divides n and differs from d
    logic next_d;    // advance to the next trial divisor
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic sq_le_n;   // d*d <= n
    logic div_last;  // last division step this cycle
  } status_t;

endpackage

// ===== hw/rtl/proper_divisor_sum_classifier.sv =====
// Per item: accept, then for each trial divisor d = 2, 3, ... while d*d <= n,
//   check, divide bit-serially, add d and n/d when d divides n; then finish.
// One item at a time: a new number is accepted only after the last result is loaded.
// A finished result waits in the output register while the next item runs.
// Reset (rst_ni low, async) returns the controller to idle and empties the
//   output register; the datapath and output data registers are not reset.
// ----------------------------------------------------------------------------
// proper_divisor_sum_classifier
// Sum of proper divisors by trial division, with perfect and prime flags.
// ----------------------------------------------------------------------------
`include "proper_divisor_sum_classifier_defines.svh"

module proper_divisor_sum_classifier
  import pdsc_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: [DATA_WIDTH-1:0] number, zero padded to bytes
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: [35:0] divisor_sum, [36] is_perfect, [37] is_prime, [39:38] zero
  output logic [OUT_W-1:0]                    m_axis_tdata
);

  localparam int unsigned ACC_W = DATA_WIDTH + 4;

  cmd_t             cmd;
  status_t          status;
  logic             out_load;
  logic             out_free;
  logic [ACC_W-1:0] total;
  logic             is_perfect;
  logic             is_prime;
  logic [SUM_W-1:0] sum_sat;

  logic             m_valid_q;
  logic [OUT_W-1:0] m_data_q;

  // Controller
  pdsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .out_free_i (out_free),
    .status_i   (status),
    .in_ready_o (s_axis_tready),
    .out_load_o (out_load),
    .cmd_o      (cmd)
  );

  // Datapath
  pdsc_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .number_i     (s_axis_tdata[DATA_WIDTH-1:0]),
    .status_o     (status),
    .total_o      (total),
    .is_perfect_o (is_perfect),
    .is_prime_o   (is_prime)
  );

  // Fit the exact sum into the result field, saturating when it is wider
  if (ACC_W > SUM_W) begin : g_sat
    assign sum_sat = (|total[ACC_W-1:SUM_W]) ? '1 : total[SUM_W-1:0];
  end else begin : g_ext
    assign sum_sat = SUM_W'(total);
  end

  // Output register
  assign out_free = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= OUT_W'({is_prime, is_perfect, sum_sat});
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Checks
  `PDSC_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `PDSC_ASSERT_NOW(a_flags_exclusive, m_axis_tvalid, !(m_axis_tdata[36] && m_axis_tdata[37]))
  `PDSC_ASSERT_NEXT(a_hold_while_stalled, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `PDSC_ASSERT_NOW(a_load_when_free, out_load, out_free && !s_axis_tready)

endmodule

// ===== hw/rtl/pdsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pdsc_ctrl
// Sequencer for the trial-division loop: check, divide, accumulate, advance.
// ----------------------------------------------------------------------------
module pdsc_ctrl
  import pdsc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    out_free_i,
  input  status_t status_i,
  output logic    in_ready_o,
  output logic    out_load_o,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = status_i.sq_le_n ? ST_DIV : ST_FINISH;
      end
      ST_DIV: begin
        if (status_i.div_last) state_d = ST_ACC_D;
      end
      ST_ACC_D: begin
        state_d = ST_ACC_Q;
      end
      ST_ACC_Q: begin
        state_d = ST_CHECK;
      end
      ST_FINISH: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CHECK: begin
        cmd_o.div_init = status_i.sq_le_n;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      ST_ACC_D: begin
        cmd_o.add_d = 1'b1;
      end
      ST_ACC_Q: begin
        cmd_o.add_q  = 1'b1;
        cmd_o.next_d = 1'b1;
      end
      ST_FINISH: begin
        out_load_o = out_free_i;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/pdsc_datapath.sv =====
// ----------------------------------------------------------------------------
// pdsc_datapath
// Trial divisor and its square, bit-serial restoring divider, sum accumulator.
// ----------------------------------------------------------------------------
module pdsc_datapath
  import pdsc_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  cmd_t                  cmd_i,
  input  logic [DATA_WIDTH-1:0] number_i,
  output status_t               status_o,
  output logic [DATA_WIDTH+3:0] total_o,
  output logic                  is_perfect_o,
  output logic                  is_prime_o
);

  localparam int unsigned ACC_W = DATA_WIDTH + 4;
  localparam int unsigned D_W   = (DATA_WIDTH + 1) / 2 + 1;
  localparam int unsigned SQ_W  = DATA_WIDTH + 2;
  localparam int unsigned CNT_W = $clog2(DATA_WIDTH);

  logic [DATA_WIDTH-1:0] n_q;
  logic [D_W-1:0]        d_q;
  logic [SQ_W-1:0]       sq_q;
  logic [D_W-1:0]        rem_q;
  logic [DATA_WIDTH-1:0] quo_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [ACC_W-1:0]      tot_q;

  logic [D_W:0] rem_sh;
  logic [D_W:0] rem_diff;
  logic         rem_ge;
  logic         rem_zero;
  logic         q_eq_d;

  // Restoring division step: shift in next dividend bit, try subtract
  // (d stays below 2^(D_W-1), so the top bit of the difference is the borrow)
  assign rem_sh   = {rem_q, quo_q[DATA_WIDTH-1]};
  assign rem_diff = rem_sh - {1'b0, d_q};
  assign rem_ge   = !rem_diff[D_W];
  assign rem_zero = (rem_q == '0);
  assign q_eq_d   = (quo_q == DATA_WIDTH'(d_q));

  // Datapath registers (no reset needed: every item starts with load)
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q   <= number_i;
      d_q   <= D_W'(2);
      sq_q  <= SQ_W'(4);
      tot_q <= (number_i == DATA_WIDTH'(1)) ? '0 : ACC_W'(1);
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      quo_q <= n_q;
      cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_ge ? rem_diff[D_W-1:0] : rem_sh[D_W-1:0];
      quo_q <= {quo_q[DATA_WIDTH-2:0], rem_ge};
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (cmd_i.add_d && rem_zero) begin
      tot_q <= tot_q + ACC_W'(d_q);
    end
    if (cmd_i.add_q && rem_zero && !q_eq_d) begin
      tot_q <= tot_q + ACC_W'(quo_q);
    end
    // (d+1)^2 = d^2 + 2d + 1
    if (cmd_i.next_d) begin
      d_q  <= d_q + D_W'(1);
      sq_q <= sq_q + SQ_W'({d_q, 1'b1});
    end
  end

  // Status and result flags
  assign status_o.sq_le_n  = (sq_q <= SQ_W'(n_q));
  assign status_o.div_last = (cnt_q == CNT_W'(DATA_WIDTH - 1));

  assign total_o      = tot_q;
  assign is_perfect_o = (n_q != '0) && (tot_q == ACC_W'(n_q));
  assign is_prime_o   = (tot_q == ACC_W'(1));

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for proper_divisor_sum_classifier
// Drives numbers into the stream input and checks each divisor sum and its
// perfect/prime flags against a trial-division predictor kept in the bench.
// Covers the special numbers, the field extremes, output backpressure that
// fills the block, and random numbers with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench
  import pdsc_pkg::*;
();

  localparam int unsigned NUM_W      = 32;
  localparam int unsigned IN_W       = ((NUM_W + 7) / 8) * 8;
  localparam int unsigned IDLE_LIMIT = 8_000_000;
  localparam int unsigned HOLD_LEN   = 3000;
  localparam int unsigned MAX_SHOWN  = 10;
  localparam logic [63:0] SUM_SAT    = (64'd1 << SUM_W) - 64'd1;

  // Expected result of one item
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             perfect;
    logic             prime;
  } aliquot_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata;   // [31:0] number
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OUT_W-1:0]  m_axis_tdata;   // [35:0] divisor_sum, [36] is_perfect, [37] is_prime

  aliquot_t    pending_sums[$];
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned rx_hold_left;
  bit          idle_en;

  proper_divisor_sum_classifier #(
    .DATA_WIDTH(NUM_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Clock, period 2
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Sum of proper divisors by trial division, flags on the exact sum
  function automatic aliquot_t aliquot_of(input logic [NUM_W-1:0] number);
    longint unsigned n;
    longint unsigned total;
    longint unsigned d;
    longint unsigned q;
    aliquot_t        r;
    n = number;
    if (n == 1) begin
      total = 0;
    end else begin
      total = 1;
      for (d = 2; d * d <= n; d++) begin
        if (n % d == 0) begin
          q = n / d;
          total += (q == d) ? d : d + q;
        end
      end
    end
    r.sum     = (total > SUM_SAT) ? SUM_SAT[SUM_W-1:0] : total[SUM_W-1:0];
    r.perfect = (n != 0) && (total == n);
    r.prime   = (total == 1);
    return r;
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    aliquot_t want;
    aliquot_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.sum     = m_axis_tdata[SUM_W-1:0];
      got.perfect = m_axis_tdata[SUM_W];
      got.prime   = m_axis_tdata[SUM_W+1];
      if (pending_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("ERROR: unexpected result sum=%0d perfect=%0b prime=%0b",
                   got.sum, got.perfect, got.prime);
      end else begin
        want = pending_sums.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("ERROR: sum exp %0d got %0d, perfect exp %0b got %0b, prime exp %0b got %0b",
                     want.sum, got.sum, want.perfect, got.perfect, want.prime, got.prime);
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus a long hold when requested
  initial begin
    int unsigned stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_left > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold_left--;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (idle_en && $urandom_range(0, 5) == 0)
          stall_left = $urandom_range(1, 18);
      end
    end
  end

  // Offer one number, with an optional idle burst ahead of it
  task automatic offer_number(input logic [NUM_W-1:0] number);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= number;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_sums.push_back(aliquot_of(number));
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_results_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk_i);
  endtask

  // Zero, one, primes, squares and perfect numbers
  task automatic test_special_numbers();
    logic [NUM_W-1:0] picks[$] = '{0, 1, 2, 3, 4, 6, 9, 12, 16, 25, 28, 49,
                                   97, 496, 8128, 65536, 65537, 999983};
    foreach (picks[i]) offer_number(picks[i]);
    wait_results_drained();
  endtask

  // Large numbers: a perfect number, 2^20 and the all-ones maximum
  task automatic test_extremes();
    offer_number(32'd33550336);
    offer_number(32'd1048576);
    offer_number(32'hFFFF_FFFF);
    wait_results_drained();
  endtask

  // Long output hold while tiny numbers keep coming, so the input stalls
  task automatic test_backpressure_fill();
    @(negedge clk_i);
    rx_hold_left = HOLD_LEN;
    repeat (10) offer_number($urandom_range(0, 15));
    wait_results_drained();
  endtask

  // Random numbers, mostly small so the run stays short
  task automatic test_random_numbers(input int unsigned count);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 15)
        offer_number($urandom_range(0, 63));
      else if (pick < 85)
        offer_number($urandom_range(0, 4095));
      else
        offer_number($urandom & 32'h0003_FFFF);
    end
  endtask

  initial begin
    mismatches    = 0;
    quiet_cycles  = 0;
    rx_hold_left  = 0;
    idle_en       = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    rst_ni        = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    test_special_numbers();
    test_extremes();
    test_backpressure_fill();
    test_random_numbers(40);
    // last stretch runs without idling on either side
    idle_en = 1'b0;
    wait_results_drained();
    test_random_numbers(30);
    wait_results_drained();
    repeat (50) @(posedge clk_i);

    if (pending_sums.size() != 0) mismatches++;
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
